FILE: hdl/pwh_pkg.sv
// ----------------------------------------------------------------------------
// PID with weighted error history: shared package
// Datapath command codes, controller/datapath structs, register indexes,
// reset values and a 32-bit saturation helper.
// ----------------------------------------------------------------------------
package pwh_pkg;

  localparam int DEF_HISTORY_DEPTH = 4;
  localparam int DEF_FRAC_BITS     = 16;
  localparam int DATA_W            = 32;
  localparam int DT_W              = 31;
  localparam int DECAY_W           = 17;
  localparam int CFG_IDX_W         = 3;
  localparam int DIV_STEPS         = 64;
  localparam int DIV_CNT_W         = 6;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_DECAY = 3'd5;

  localparam logic signed [DATA_W-1:0] RST_GAIN_P        = 32'sd65536;
  localparam logic signed [DATA_W-1:0] RST_GAIN_I        = 32'sd6554;
  localparam logic signed [DATA_W-1:0] RST_GAIN_D        = 32'sd3277;
  localparam logic signed [DATA_W-1:0] RST_INTEGRAL_LOW  = -32'sd205887;
  localparam logic signed [DATA_W-1:0] RST_INTEGRAL_HIGH = 32'sd205887;
  localparam logic [DECAY_W-1:0]       RST_HISTORY_DECAY = 17'd32768;

  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;
  localparam logic [3:0] OP_ERR     = 4'd2;
  localparam logic [3:0] OP_MUL_GI  = 4'd3;
  localparam logic [3:0] OP_MUL_DT  = 4'd4;
  localparam logic [3:0] OP_INTEG   = 4'd5;
  localparam logic [3:0] OP_HMUL    = 4'd6;
  localparam logic [3:0] OP_HACC    = 4'd7;
  localparam logic [3:0] OP_HW      = 4'd8;
  localparam logic [3:0] OP_COMB    = 4'd9;
  localparam logic [3:0] OP_MUL_GP  = 4'd10;
  localparam logic [3:0] OP_PTERM   = 4'd11;
  localparam logic [3:0] OP_DIVINIT = 4'd12;
  localparam logic [3:0] OP_DIVSTEP = 4'd13;
  localparam logic [3:0] OP_DFIN    = 4'd14;
  localparam logic [3:0] OP_FINISH  = 4'd15;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic dt_zero;
  } sts_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [67:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > 68'sh0_0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -68'sh0_0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/pwh_if.sv
// ----------------------------------------------------------------------------
// PID with weighted error history: channel interfaces
// Input word (setpoint, measurement, time step) and output word channels.
// ----------------------------------------------------------------------------
interface pwh_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pwh_pkg::DATA_W-1:0]     target_value;
  logic signed [pwh_pkg::DATA_W-1:0]     measured;
  logic        [pwh_pkg::DT_W-1:0]       time_step;
  modport source (output valid, target_value, measured, time_step, input ready);
  modport sink   (input valid, target_value, measured, time_step, output ready);
endinterface

interface pwh_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pwh_pkg::DATA_W-1:0]     drive;
  logic                                  zero_step;
  modport source (output valid, drive, zero_step, input ready);
  modport sink   (input valid, drive, zero_step, output ready);
endinterface

FILE: hdl/pwh_datapath.sv
// ----------------------------------------------------------------------------
// PID with weighted error history: datapath
// Configuration registers, state, one shared multiplier and a restoring
// divider, all driven by commands from the controller.
// ----------------------------------------------------------------------------
module pwh_datapath #(
  parameter int HISTORY_DEPTH = pwh_pkg::DEF_HISTORY_DEPTH,
  parameter int FRAC_BITS     = pwh_pkg::DEF_FRAC_BITS,
  parameter int KW            = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [pwh_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pwh_pkg::DATA_W-1:0]           cfg_data,
  input  logic signed [pwh_pkg::DATA_W-1:0]    in_target_value,
  input  logic signed [pwh_pkg::DATA_W-1:0]    in_measured,
  input  logic [pwh_pkg::DT_W-1:0]             in_time_step,
  input  pwh_pkg::cmd_t                        cmd,
  input  logic [KW-1:0]                        k,
  output pwh_pkg::sts_t                        sts,
  output logic signed [pwh_pkg::DATA_W-1:0]    drive,
  output logic                                 zero_step
);

  localparam int WW   = FRAC_BITS + 1;
  localparam int ACCW = FRAC_BITS + 33 + KW;
  localparam logic [WW-1:0] W_ONE = WW'(1) << FRAC_BITS;

  logic signed [31:0] gain_p, gain_i, gain_d, integral_low, integral_high;
  logic [pwh_pkg::DECAY_W-1:0] history_decay;

  logic signed [31:0] sp, mv, err, comb, integ, dterm, integral_acc;
  logic [pwh_pkg::DT_W-1:0] dt;
  logic signed [31:0] hist [HISTORY_DEPTH];
  logic signed [65:0] prod, pterm;
  logic [WW-1:0] w;
  logic signed [ACCW-1:0] acc;
  logic [30:0] rem;
  logic [63:0] quo;
  logic neg;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod_sh;
  logic signed [31:0] t_sat;
  logic [31:0] dec32;
  logic [WW-1:0] dec_eff;
  logic signed [67:0] isum, csum, tsum;
  logic signed [32:0] esub;
  logic [31:0] rem_sh;
  logic [32:0] trial;
  logic signed [31:0] qsat;

  always_comb begin
    prod_sh = prod >>> FRAC_BITS;
    t_sat   = pwh_pkg::sat32(68'(prod_sh));
    dec32   = 32'(history_decay);
    dec_eff = (dec32 > (32'd1 << FRAC_BITS)) ? W_ONE : dec32[WW-1:0];
    esub    = 33'(sp) - 33'(mv);
    isum    = 68'(integral_acc) + 68'(prod_sh);
    csum    = 68'(err) + 68'(acc >>> FRAC_BITS);
    tsum    = 68'(pterm) + 68'(integ) + 68'(dterm);
    rem_sh  = {rem, quo[63]};
    trial   = {1'b0, rem_sh} - 33'(dt);
    if (neg) begin
      qsat = (quo[63:31] != 33'd0) ? 32'sh8000_0000 : -$signed(quo[31:0]);
    end else begin
      qsat = (quo[63:31] != 33'd0) ? 32'sh7FFF_FFFF : $signed(quo[31:0]);
    end
    ma = '0;
    mb = '0;
    case (cmd.op)
      pwh_pkg::OP_MUL_GI: begin
        ma = 33'(gain_i);
        mb = 33'(err);
      end
      pwh_pkg::OP_MUL_DT: begin
        ma = 33'(t_sat);
        mb = $signed(33'(dt));
      end
      pwh_pkg::OP_HMUL: begin
        ma = $signed(33'(w));
        mb = 33'(hist[k]);
      end
      pwh_pkg::OP_HACC: begin
        ma = $signed(33'(w));
        mb = $signed(33'(dec_eff));
      end
      pwh_pkg::OP_MUL_GP: begin
        ma = 33'(gain_p);
        mb = 33'(comb);
      end
      pwh_pkg::OP_PTERM: begin
        ma = 33'(gain_d);
        mb = 33'(err) - 33'(hist[0]);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign sts.dt_zero = (dt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p        <= pwh_pkg::RST_GAIN_P;
      gain_i        <= pwh_pkg::RST_GAIN_I;
      gain_d        <= pwh_pkg::RST_GAIN_D;
      integral_low  <= pwh_pkg::RST_INTEGRAL_LOW;
      integral_high <= pwh_pkg::RST_INTEGRAL_HIGH;
      history_decay <= pwh_pkg::RST_HISTORY_DECAY;
    end else if (cfg_we) begin
      case (cfg_index)
        pwh_pkg::REG_GAIN_P:        gain_p        <= cfg_data;
        pwh_pkg::REG_GAIN_I:        gain_i        <= cfg_data;
        pwh_pkg::REG_GAIN_D:        gain_d        <= cfg_data;
        pwh_pkg::REG_INTEGRAL_LOW:  integral_low  <= cfg_data;
        pwh_pkg::REG_INTEGRAL_HIGH: integral_high <= cfg_data;
        pwh_pkg::REG_HISTORY_DECAY: history_decay <= cfg_data[pwh_pkg::DECAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else if (cmd.op == pwh_pkg::OP_FINISH) begin
      integral_acc <= integ;
      hist[0]      <= err;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      pwh_pkg::OP_LOAD: begin
        sp <= in_target_value;
        mv <= in_measured;
        dt <= in_time_step;
      end
      pwh_pkg::OP_ERR: err <= pwh_pkg::sat32(68'(esub));
      pwh_pkg::OP_MUL_GI, pwh_pkg::OP_MUL_DT, pwh_pkg::OP_HMUL, pwh_pkg::OP_MUL_GP: begin
        prod <= ma * mb;
      end
      pwh_pkg::OP_INTEG: begin
        if (isum > 68'(integral_high)) begin
          integ <= integral_high;
        end else if (isum < 68'(integral_low)) begin
          integ <= integral_low;
        end else begin
          integ <= isum[31:0];
        end
        acc <= '0;
        w   <= W_ONE;
      end
      pwh_pkg::OP_HACC: begin
        acc  <= acc + ACCW'(prod);
        prod <= ma * mb;
      end
      pwh_pkg::OP_HW: w <= prod_sh[WW-1:0];
      pwh_pkg::OP_COMB: comb <= pwh_pkg::sat32(csum);
      pwh_pkg::OP_PTERM: begin
        pterm <= prod_sh;
        prod  <= ma * mb;
      end
      pwh_pkg::OP_DIVINIT: begin
        neg <= prod[65];
        rem <= '0;
        quo <= prod[65] ? 64'(-prod) : prod[63:0];
      end
      pwh_pkg::OP_DIVSTEP: begin
        if (!trial[32]) begin
          rem <= trial[30:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rem_sh[30:0];
          quo <= {quo[62:0], 1'b0};
        end
      end
      pwh_pkg::OP_DFIN: dterm <= sts.dt_zero ? 32'sd0 : qsat;
      pwh_pkg::OP_FINISH: begin
        drive     <= pwh_pkg::sat32(tsum);
        zero_step <= sts.dt_zero;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hdl/pwh_ctrl.sv
// ----------------------------------------------------------------------------
// PID with weighted error history: controller
// Sequences one word through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module pwh_ctrl #(
  parameter int HISTORY_DEPTH = pwh_pkg::DEF_HISTORY_DEPTH,
  parameter int KW            = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output pwh_pkg::cmd_t cmd,
  output logic [KW-1:0] k,
  input  pwh_pkg::sts_t sts
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ERR   = 4'd1;
  localparam logic [3:0] S_MGI   = 4'd2;
  localparam logic [3:0] S_MDT   = 4'd3;
  localparam logic [3:0] S_INTEG = 4'd4;
  localparam logic [3:0] S_HMUL  = 4'd5;
  localparam logic [3:0] S_HACC  = 4'd6;
  localparam logic [3:0] S_HW    = 4'd7;
  localparam logic [3:0] S_COMB  = 4'd8;
  localparam logic [3:0] S_MGP   = 4'd9;
  localparam logic [3:0] S_PTERM = 4'd10;
  localparam logic [3:0] S_DINIT = 4'd11;
  localparam logic [3:0] S_DSTEP = 4'd12;
  localparam logic [3:0] S_DFIN  = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;
  localparam logic [KW-1:0] K_LAST = KW'(HISTORY_DEPTH - 1);
  localparam logic [pwh_pkg::DIV_CNT_W-1:0] D_LAST =
    pwh_pkg::DIV_CNT_W'(pwh_pkg::DIV_STEPS - 1);

  logic [3:0] state, state_next;
  logic [KW-1:0] k_next;
  logic [pwh_pkg::DIV_CNT_W-1:0] dcnt, dcnt_next;
  logic out_valid_next;
  logic fin_ok;

  assign in_ready = (state == S_IDLE);
  assign fin_ok   = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    k_next         = k;
    dcnt_next      = dcnt;
    out_valid_next = out_valid && !out_ready;
    cmd.op         = pwh_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = pwh_pkg::OP_LOAD;
          state_next = S_ERR;
        end
      end
      S_ERR: begin
        cmd.op     = pwh_pkg::OP_ERR;
        state_next = S_MGI;
      end
      S_MGI: begin
        cmd.op     = pwh_pkg::OP_MUL_GI;
        state_next = S_MDT;
      end
      S_MDT: begin
        cmd.op     = pwh_pkg::OP_MUL_DT;
        state_next = S_INTEG;
      end
      S_INTEG: begin
        cmd.op     = pwh_pkg::OP_INTEG;
        k_next     = '0;
        state_next = S_HMUL;
      end
      S_HMUL: begin
        cmd.op     = pwh_pkg::OP_HMUL;
        state_next = S_HACC;
      end
      S_HACC: begin
        cmd.op     = pwh_pkg::OP_HACC;
        state_next = S_HW;
      end
      S_HW: begin
        cmd.op = pwh_pkg::OP_HW;
        if (k == K_LAST) begin
          state_next = S_COMB;
        end else begin
          k_next     = k + KW'(1);
          state_next = S_HMUL;
        end
      end
      S_COMB: begin
        cmd.op     = pwh_pkg::OP_COMB;
        state_next = S_MGP;
      end
      S_MGP: begin
        cmd.op     = pwh_pkg::OP_MUL_GP;
        state_next = S_PTERM;
      end
      S_PTERM: begin
        cmd.op     = pwh_pkg::OP_PTERM;
        state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.op     = pwh_pkg::OP_DIVINIT;
        dcnt_next  = '0;
        state_next = sts.dt_zero ? S_DFIN : S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op    = pwh_pkg::OP_DIVSTEP;
        dcnt_next = dcnt + pwh_pkg::DIV_CNT_W'(1);
        if (dcnt == D_LAST) begin
          state_next = S_DFIN;
        end
      end
      S_DFIN: begin
        cmd.op     = pwh_pkg::OP_DFIN;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (fin_ok) begin
          cmd.op         = pwh_pkg::OP_FINISH;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= '0;
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      k         <= k_next;
      dcnt      <= dcnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: hdl/pid_with_weighted_error_history.sv
// ----------------------------------------------------------------------------
// PID with weighted error history: top level
// Channel   | Dir | Payload
// in_ch     | in  | target_value, measured, time_step
// out_ch    | out | drive, zero_step
// cfg port  | in  | cfg_we, cfg_index, cfg_data
// A result is presented once the whole sequence for its word has run, and the next
// word can be taken in the same cycle as the result is presented; most of the
// sequence is the 64-step restoring divider of the derivative term, which is
// skipped when time_step is zero.
// A finished word waits in the output register while the next is accepted.
// Reset is synchronous and restores registers, integral and history.
// ----------------------------------------------------------------------------
module pid_with_weighted_error_history #(
  parameter int HISTORY_DEPTH = pwh_pkg::DEF_HISTORY_DEPTH,
  parameter int FRAC_BITS     = pwh_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  pwh_in_if.sink                        in_ch,
  pwh_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [pwh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pwh_pkg::DATA_W-1:0]    cfg_data
);

  localparam int KW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  pwh_pkg::cmd_t cmd;
  pwh_pkg::sts_t sts;
  logic [KW-1:0] k;

  pwh_ctrl #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .KW(KW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .cmd(cmd),
    .k(k),
    .sts(sts)
  );

  pwh_datapath #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .FRAC_BITS(FRAC_BITS),
    .KW(KW)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_target_value(in_ch.target_value),
    .in_measured(in_ch.measured),
    .in_time_step(in_ch.time_step),
    .cmd(cmd),
    .k(k),
    .sts(sts),
    .drive(out_ch.drive),
    .zero_step(out_ch.zero_step)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while a word is in progress");

  a_load_on_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == pwh_pkg::OP_LOAD) |-> (in_ch.valid && in_ch.ready))
    else $error("datapath loaded without an accepted word");

  a_finish_shows_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == pwh_pkg::OP_FINISH) |=> out_ch.valid)
    else $error("finished word not presented");

endmodule

FILE: bench/pid_with_weighted_error_history_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID with weighted error history: result checker
// Watches the input and output channels and the register write port, keeps
// its own copy of the gains, clamps, integral and error history, predicts
// drive and zero_step for every accepted word and compares them in order.
// ----------------------------------------------------------------------------
module pid_with_weighted_error_history_checker (
  input  logic                          clk,
  input  logic                          rst,
  pwh_in_if.sink                        in_ch,
  pwh_out_if.sink                       out_ch,
  input  logic                          cfg_we,
  input  logic [pwh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pwh_pkg::DATA_W-1:0]    cfg_data,
  output int                            fail_count,
  output int                            pending
);

  localparam int HDEPTH = pwh_pkg::DEF_HISTORY_DEPTH;
  localparam int FB     = pwh_pkg::DEF_FRAC_BITS;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               zero_step;
  } pid_result_t;

  logic signed [31:0] kp, ki, kd, clamp_lo, clamp_hi, integ_acc;
  logic [16:0]        decay;
  logic signed [31:0] err_hist [HDEPTH];
  pid_result_t        expected_q [$];

  function automatic longint clip32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic predict_drive(input logic signed [31:0] sp, input logic signed [31:0] mv,
                               input logic [30:0] dt);
    longint err, t, integ, d, acc, comb, p, w, dec, dtl;
    pid_result_t r;
    dtl = longint'(dt);
    err = clip32(longint'(sp) - longint'(mv));
    t = clip32((longint'(ki) * err) >>> FB);
    integ = longint'(integ_acc) + ((t * dtl) >>> FB);
    if (integ > longint'(clamp_hi)) integ = longint'(clamp_hi);
    else if (integ < longint'(clamp_lo)) integ = longint'(clamp_lo);
    integ_acc = integ[31:0];
    r.zero_step = (dt == 0);
    if (dt == 0) d = 0;
    else d = clip32((longint'(kd) * (err - longint'(err_hist[0]))) / dtl);
    dec = (decay > 17'd65536) ? 65536 : longint'(decay);
    w = 65536;
    acc = 0;
    for (int k = 0; k < HDEPTH; k++) begin
      acc += w * longint'(err_hist[k]);
      w = (w * dec) >>> FB;
    end
    comb = clip32(err + (acc >>> FB));
    p = (longint'(kp) * comb) >>> FB;
    for (int k = HDEPTH - 1; k > 0; k--) err_hist[k] = err_hist[k-1];
    err_hist[0] = err[31:0];
    r.drive = 32'(clip32(p + integ + d));
    expected_q.push_back(r);
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      kp = pwh_pkg::RST_GAIN_P; ki = pwh_pkg::RST_GAIN_I; kd = pwh_pkg::RST_GAIN_D;
      clamp_lo = pwh_pkg::RST_INTEGRAL_LOW; clamp_hi = pwh_pkg::RST_INTEGRAL_HIGH;
      decay = pwh_pkg::RST_HISTORY_DECAY; integ_acc = 0;
      for (int k = 0; k < HDEPTH; k++) err_hist[k] = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pwh_pkg::REG_GAIN_P:        kp = cfg_data;
          pwh_pkg::REG_GAIN_I:        ki = cfg_data;
          pwh_pkg::REG_GAIN_D:        kd = cfg_data;
          pwh_pkg::REG_INTEGRAL_LOW:  clamp_lo = cfg_data;
          pwh_pkg::REG_INTEGRAL_HIGH: clamp_hi = cfg_data;
          pwh_pkg::REG_HISTORY_DECAY: decay = cfg_data[16:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected word drive", out_ch.drive, 0);
        end else begin
          pid_result_t e;
          e = expected_q.pop_front();
          if (out_ch.drive !== e.drive) report("drive", out_ch.drive, e.drive);
          if (out_ch.zero_step !== e.zero_step)
            report("zero_step", out_ch.zero_step, e.zero_step);
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_drive(in_ch.target_value, in_ch.measured, in_ch.time_step);
    end
    pending = expected_q.size();
  end
endmodule

FILE: bench/pid_with_weighted_error_history_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID with weighted error history: testbench top
// Drives directed and random setpoint/measurement/time step words with random
// gaps and output stalls, rewrites the registers between phases while idle,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module pid_with_weighted_error_history_tb;

  localparam int DRAIN_CYCLES = 200;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk, rst;
  logic cfg_we;
  logic [pwh_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pwh_pkg::DATA_W-1:0] cfg_data;
  int fail_count, pending;
  longint cycle_count;
  bit out_stall_on;

  pwh_in_if  in_ch ();
  pwh_out_if out_ch ();

  pid_with_weighted_error_history dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pid_with_weighted_error_history_checker chk (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.sink),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Receiver stalls: a random wait before each word is taken, while out_stall_on is set.
  initial begin
    int wait_cycles;
    out_ch.ready = 0;
    @(posedge clk);
    forever begin
      wait_cycles = out_stall_on ? $urandom_range(0, 8) : 0;
      if (wait_cycles != 0) begin
        out_ch.ready <= 0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ch.ready <= 1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic write_reg(input logic [pwh_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pwh_pkg::DATA_W-1:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_word(input logic [31:0] sp, input logic [31:0] mv, input logic [30:0] dt,
                           input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1; in_ch.target_value <= sp; in_ch.measured <= mv; in_ch.time_step <= dt;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic [31:0] rand_val(input int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 400000) - 200000;
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
    endcase
  endfunction

  function automatic logic [30:0] rand_dt();
    case ($urandom_range(0, 5))
      0: return 31'd0;
      1: return 31'($urandom());
      2: return 31'h7FFFFFFF;
      default: return 31'($urandom_range(1, 200000));
    endcase
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      send_word(rand_val($urandom_range(0, 3)), rand_val($urandom_range(0, 3)), rand_dt(),
                (i % 200) < 150);
      if (i == n / 2) begin
        in_ch.valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    in_ch.valid <= 0;
  endtask

  initial begin
    rst = 1; cfg_we = 0; cfg_index = 0; cfg_data = 0; out_stall_on = 1;
    in_ch.valid = 0; in_ch.target_value = 0; in_ch.measured = 0; in_ch.time_step = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_word(32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF, 1);
    send_word(32'h80000000, 32'h7FFFFFFF, 31'd1, 1);
    send_word(32'h00010000, 32'h00000000, 31'd0, 1);
    send_word(32'h00000000, 32'h00010000, 31'd65536, 0);
    send_word(32'hFFFFFFFF, 32'h00000000, 31'h40000000, 0);
    send_word(32'h00000000, 32'h00000000, 31'd0, 1);
    send_word(32'h00050000, 32'hFFFB0000, 31'd6554, 0);
    send_word(32'h55555555, 32'hAAAAAAAA, 31'h2AAAAAAA, 1);
    in_ch.valid <= 0;
    wait_idle();

    // Decay above one, crossed clamps and extreme gains.
    write_reg(pwh_pkg::REG_HISTORY_DECAY, 32'h1FFFF);
    write_reg(pwh_pkg::REG_INTEGRAL_LOW, 32'h00100000);
    write_reg(pwh_pkg::REG_INTEGRAL_HIGH, 32'hFFF00000);
    write_reg(pwh_pkg::REG_GAIN_P, 32'h7FFFFFFF);
    write_reg(pwh_pkg::REG_GAIN_I, 32'h80000000);
    write_reg(pwh_pkg::REG_GAIN_D, 32'h7FFFFFFF);
    write_reg(3'd7, 32'h12345678);
    send_word(32'h00030000, 32'h00000000, 31'd65536, 0);
    send_word(32'hFFFD0000, 32'h00000000, 31'd0, 0);
    send_word(32'h7FFFFFFF, 32'h80000000, 31'd1, 1);
    send_word(32'h00000001, 32'h00000000, 31'h7FFFFFFF, 1);
    in_ch.valid <= 0;
    wait_idle();
    random_phase(300);
    wait_idle();

    write_reg(pwh_pkg::REG_HISTORY_DECAY, 32'd0);
    write_reg(pwh_pkg::REG_INTEGRAL_LOW, 32'h80000000);
    write_reg(pwh_pkg::REG_INTEGRAL_HIGH, 32'h7FFFFFFF);
    write_reg(pwh_pkg::REG_GAIN_P, 32'h80000000);
    write_reg(pwh_pkg::REG_GAIN_I, 32'h7FFFFFFF);
    write_reg(pwh_pkg::REG_GAIN_D, 32'h80000000);
    out_stall_on = 0;
    random_phase(400);
    wait_idle();
    out_stall_on = 1;

    write_reg(pwh_pkg::REG_HISTORY_DECAY, 32'd65536);
    write_reg(pwh_pkg::REG_GAIN_P, 32'h00010000);
    write_reg(pwh_pkg::REG_GAIN_I, 32'h00001999);
    write_reg(pwh_pkg::REG_GAIN_D, 32'h00000CCD);
    write_reg(pwh_pkg::REG_INTEGRAL_LOW, 32'hFFFCDBC1);
    write_reg(pwh_pkg::REG_INTEGRAL_HIGH, 32'h0003243F);
    random_phase(500);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(pwh_pkg::REG_GAIN_P, $urandom());
      write_reg(pwh_pkg::REG_GAIN_I,
                $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 200000));
      write_reg(pwh_pkg::REG_GAIN_D, $urandom());
      write_reg(pwh_pkg::REG_INTEGRAL_LOW, $urandom());
      write_reg(pwh_pkg::REG_INTEGRAL_HIGH, $urandom());
      write_reg(pwh_pkg::REG_HISTORY_DECAY, $urandom_range(0, 131071));
      random_phase(200);
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
